[hw/rtl/tick_task_scheduler_macros.svh]
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication check on clk, dropped while rst_n is low.
`define TTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check on clk, dropped while rst_n is low.
`define TTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tts_pkg.sv]
`default_nettype none

package tts_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int MAX_RUNS   = 8;
    localparam int RUN_CNT_W  = $clog2(MAX_RUNS + 1);

    // command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_DEL      = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // reply status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // sticky error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  slot;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic        cooperative;
    } tts_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] task_slot;
        logic [1:0] status;
        logic [1:0] error_code;
        logic       last;
    } tts_rsp_t;

    // classified item held in the queue between front and engine
    typedef struct packed {
        logic [1:0]       op;
        logic             walk;
        logic [2:0]       slot;
        logic [IDX_W-1:0] idx;
        logic             idx_ok;
        logic [15:0]      delay;
        logic [15:0]      period;
        logic             coop;
    } tts_job_t;

    typedef struct packed {
        logic busy;
        logic hold;
    } tts_eng_status_t;

endpackage

`default_nettype wire

[hw/rtl/tts_front.sv]
`default_nettype none

module tts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tts_pkg::tts_req_t req,
    output logic              job_valid,
    output tts_pkg::tts_job_t job,
    input  logic              job_pop
);
    import tts_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    tts_job_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    tts_job_t   job_in;
    logic       push;

    always_comb
    begin
        job_in.op     = req.cmd;
        job_in.walk   = (req.cmd == CMD_TICK) || (req.cmd == CMD_DISPATCH);
        job_in.slot   = req.slot;
        job_in.idx    = IDX_W'(req.slot);
        job_in.idx_ok = (32'(req.slot) < 32'(TASK_SLOTS));
        job_in.delay  = req.start_delay;
        job_in.period = req.repeat_period;
        job_in.coop   = req.cooperative;
    end

    assign req_stall = (cnt_reg == Q_FULL);
    assign push      = req_valid && !req_stall;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + 2'(push) - 2'(job_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (job_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= job_in;
    end

endmodule

`default_nettype wire

[hw/rtl/tts_engine.sv]
`default_nettype none

module tts_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  tts_pkg::tts_job_t        job,
    output logic                     job_pop,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output tts_pkg::tts_rsp_t        rsp,
    output tts_pkg::tts_eng_status_t status
);
    import tts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // task table
    logic        valid_reg  [TASK_SLOTS];
    logic [15:0] delay_reg  [TASK_SLOTS];
    logic [15:0] period_reg [TASK_SLOTS];
    logic [7:0]  pend_reg   [TASK_SLOTS];
    logic        coop_reg   [TASK_SLOTS];
    logic [1:0]  err_reg;
    logic [1:0]  err_next;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [IDX_W-1:0]     walk_reg, walk_next;
    logic [RUN_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [3:0]           hold_slot_reg, hold_slot_next;
    logic                 rsp_valid_reg;
    tts_rsp_t             rsp_reg, rsp_next;
    logic                 rsp_load;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             out_ready;
    logic             do_add;
    logic             do_del;
    logic             do_slot;

    // current walk slot
    logic        cur_v;
    logic [15:0] cur_d;
    logic [15:0] cur_p;
    logic [7:0]  cur_pr;
    logic        cur_c;
    logic        emit_t;
    logic        emit_d;
    logic        emit;
    logic        keep;
    logic        clear_now;
    logic [1:0]  del_st;

    assign cur_v  = valid_reg[walk_reg];
    assign cur_d  = delay_reg[walk_reg];
    assign cur_p  = period_reg[walk_reg];
    assign cur_pr = pend_reg[walk_reg];
    assign cur_c  = coop_reg[walk_reg];

    assign emit_t    = cur_v && (cur_d == 16'd0) && !cur_c;
    assign emit_d    = cur_v && cur_c && (cur_pr != 8'd0);
    assign emit      = (op_reg == CMD_TICK) ? emit_t : emit_d;
    assign keep      = emit && (cnt_reg < RUN_CNT_W'(MAX_RUNS));
    assign clear_now = emit && (cur_p == 16'd0);
    assign out_ready = !rsp_valid_reg || !rsp_stall;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        walk_next       = walk_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        err_next        = err_reg;
        rsp_next        = rsp_reg;
        rsp_load        = 1'b0;
        job_pop         = 1'b0;
        do_add          = 1'b0;
        do_del          = 1'b0;
        do_slot         = 1'b0;
        del_st          = STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.walk)
                    begin
                        job_pop         = 1'b1;
                        op_next         = job.op;
                        walk_next       = '0;
                        cnt_next        = '0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                    else if (out_ready)
                    begin
                        job_pop  = 1'b1;
                        rsp_load = 1'b1;
                        if (job.op == CMD_ADD)
                        begin
                            if (free_found)
                            begin
                                do_add   = 1'b1;
                                rsp_next = '{KIND_ADD, 4'(free_idx), STAT_OK, err_reg, 1'b1};
                            end
                            else
                            begin
                                err_next = ERR_FULL;
                                rsp_next = '{KIND_ADD, 4'(TASK_SLOTS), STAT_FULL, ERR_FULL, 1'b1};
                            end
                        end
                        else
                        begin
                            do_del = job.idx_ok;
                            // out-of-range index behaves as an empty slot
                            if (!job.idx_ok || !valid_reg[job.idx])
                            begin
                                err_next = ERR_EMPTY;
                                del_st   = STAT_EMPTY;
                            end
                            rsp_next = '{KIND_DEL, 4'(job.slot), del_st, err_next, 1'b1};
                        end
                    end
                end
            end

            ST_WALK:
            begin
                // a new run pushes the held one out, so it needs the output free
                if (!keep || !hold_valid_reg || out_ready)
                begin
                    do_slot = 1'b1;
                    if (keep)
                    begin
                        if (hold_valid_reg)
                        begin
                            rsp_load = 1'b1;
                            rsp_next = '{KIND_RUN, hold_slot_reg, STAT_OK, err_reg, 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = 4'(walk_reg);
                        cnt_next        = cnt_reg + RUN_CNT_W'(1);
                    end
                    if (walk_reg == IDX_W'(TASK_SLOTS - 1))
                        state_next = ST_DONE;
                    else
                        walk_next = walk_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    rsp_load = 1'b1;
                    if (hold_valid_reg)
                        rsp_next = '{KIND_RUN, hold_slot_reg, STAT_OK, err_reg, 1'b1};
                    else
                        rsp_next = '{KIND_NONE, 4'd0, STAT_OK, err_reg, 1'b1};
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= CMD_ADD;
            walk_reg       <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            err_reg        <= ERR_NONE;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            walk_reg       <= walk_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            err_reg        <= err_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (do_add)
                valid_reg[free_idx] <= 1'b1;
            if (do_del)
                valid_reg[job.idx] <= 1'b0;
            if (do_slot && clear_now)
                valid_reg[walk_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_slot_reg <= hold_slot_next;
        if (rsp_load)
            rsp_reg <= rsp_next;
        if (do_add)
        begin
            delay_reg[free_idx]  <= job.delay;
            period_reg[free_idx] <= job.period;
            pend_reg[free_idx]   <= 8'd0;
            coop_reg[free_idx]   <= job.coop;
        end
        if (do_slot)
        begin
            if (op_reg == CMD_TICK)
            begin
                if (cur_v)
                begin
                    if (cur_d != 16'd0)
                        delay_reg[walk_reg] <= cur_d - 16'd1;
                    else
                    begin
                        if (cur_c && (cur_pr != 8'hFF))
                            pend_reg[walk_reg] <= cur_pr + 8'd1;
                        if (cur_p != 16'd0)
                            delay_reg[walk_reg] <= cur_p;
                    end
                end
            end
            else if (emit_d)
                pend_reg[walk_reg] <= cur_pr - 8'd1;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.hold = hold_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/tick_task_scheduler.sv]
// Task scheduler over a table of TASK_SLOTS slots. Items enter a two-deep queue
// and are taken by the table engine one at a time. Add and delete each give one
// reply. Tick and dispatch walk the table one slot per clock, except while a run
// result waits on a stalled result side; each produces up to eight run results, or
// one nothing-due result, the final one flagged last. The queue keeps accepting
// items while a walk is in progress until it is full.
`default_nettype none

`include "tick_task_scheduler_macros.svh"

module tick_task_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tts_pkg::tts_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tts_pkg::tts_rsp_t rsp
);
    import tts_pkg::*;

    logic            job_valid;
    logic            job_pop;
    tts_job_t        job;
    tts_eng_status_t status;

    tts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    tts_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .status    (status)
    );

    `TTS_ASSERT_IMP(a_pop_nonempty, job_pop, job_valid, "pop from empty queue")
    `TTS_ASSERT_NXT(a_walk_starts, job_pop && job.walk, status.busy, "walk did not start")
    `TTS_ASSERT_IMP(a_idle_no_hold, !status.busy, !status.hold, "held run left in idle")
    `TTS_ASSERT_IMP(a_reply_last, rsp_valid && (rsp.kind != KIND_RUN), rsp.last,
        "single reply not marked last")
    `TTS_ASSERT_IMP(a_full_err, rsp_valid && (rsp.status == STAT_FULL),
        rsp.error_code == ERR_FULL, "full reply without full error")

endmodule

`default_nettype wire

[dv/tb_tick_task_scheduler.sv]
module tb_tick_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    tts_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    tts_rsp_t rsp;

    // table as the scheduler should hold it
    logic        tbl_live   [TASK_SLOTS];
    logic [15:0] tbl_delay  [TASK_SLOTS];
    logic [15:0] tbl_period [TASK_SLOTS];
    logic [7:0]  tbl_pend   [TASK_SLOTS];
    logic        tbl_coop   [TASK_SLOTS];
    logic [1:0]  err_latch;
    tts_rsp_t    due_replies[$];

    bit calm = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int n_results = 0;
    int n_runs = 0;
    int n_full = 0;
    int n_empty_del = 0;
    int cmd_count[4] = '{0, 0, 0, 0};

    tick_task_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tts_req_t mk_req(logic [1:0] c, logic [2:0] s, logic [15:0] d,
                                        logic [15:0] p, logic co);
        mk_req = '{cmd: c, slot: s, start_delay: d, repeat_period: p, cooperative: co};
    endfunction

    function automatic tts_rsp_t mk_rsp(logic [1:0] k, logic [3:0] s, logic [1:0] st);
        mk_rsp = '{kind: k, task_slot: s, status: st, error_code: ERR_NONE, last: 1'b0};
    endfunction

    function automatic void drop_slot(int i);
        tbl_live[i]   = 1'b0;
        tbl_delay[i]  = '0;
        tbl_period[i] = '0;
        tbl_pend[i]   = '0;
        tbl_coop[i]   = 1'b0;
    endfunction

    // Updates the table for one accepted item and queues the replies it causes.
    function automatic void apply_to_table(tts_req_t item);
        tts_rsp_t outs[$];
        int free_idx;
        int idx;
        free_idx = -1;
        idx = int'(item.slot);
        case (item.cmd)
            CMD_ADD:
            begin
                for (int i = TASK_SLOTS - 1; i >= 0; i--)
                    if (!tbl_live[i])
                        free_idx = i;
                if (free_idx < 0)
                begin
                    err_latch = ERR_FULL;
                    outs.push_back(mk_rsp(KIND_ADD, 4'(TASK_SLOTS), STAT_FULL));
                end
                else
                begin
                    tbl_live[free_idx]   = 1'b1;
                    tbl_delay[free_idx]  = item.start_delay;
                    tbl_period[free_idx] = item.repeat_period;
                    tbl_pend[free_idx]   = '0;
                    tbl_coop[free_idx]   = item.cooperative;
                    outs.push_back(mk_rsp(KIND_ADD, 4'(free_idx), STAT_OK));
                end
            end
            CMD_DEL:
            begin
                if (idx >= TASK_SLOTS || !tbl_live[idx])
                begin
                    err_latch = ERR_EMPTY;
                    outs.push_back(mk_rsp(KIND_DEL, 4'(idx), STAT_EMPTY));
                end
                else
                    outs.push_back(mk_rsp(KIND_DEL, 4'(idx), STAT_OK));
                if (idx < TASK_SLOTS)
                    drop_slot(idx);
            end
            CMD_TICK:
            begin
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (!tbl_live[i])
                        continue;
                    if (tbl_delay[i] != 0)
                    begin
                        tbl_delay[i] = tbl_delay[i] - 16'd1;
                        continue;
                    end
                    if (tbl_coop[i])
                    begin
                        if (tbl_pend[i] != 8'hFF)
                            tbl_pend[i] = tbl_pend[i] + 8'd1;
                    end
                    else
                    begin
                        if (outs.size() < MAX_RUNS)
                            outs.push_back(mk_rsp(KIND_RUN, 4'(i), STAT_OK));
                        if (tbl_period[i] == 0)
                            drop_slot(i);
                    end
                    if (tbl_period[i] != 0)
                        tbl_delay[i] = tbl_period[i];
                end
            end
            default:
            begin
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (tbl_live[i] && tbl_coop[i] && tbl_pend[i] != 0)
                    begin
                        if (outs.size() < MAX_RUNS)
                            outs.push_back(mk_rsp(KIND_RUN, 4'(i), STAT_OK));
                        tbl_pend[i] = tbl_pend[i] - 8'd1;
                        if (tbl_period[i] == 0)
                            drop_slot(i);
                    end
                end
            end
        endcase
        if (outs.size() == 0)
            outs.push_back(mk_rsp(KIND_NONE, 4'd0, STAT_OK));
        foreach (outs[k])
        begin
            outs[k].error_code = err_latch;
            outs[k].last = (k == outs.size() - 1);
            due_replies.push_back(outs[k]);
        end
    endfunction

    function automatic string fmt_rsp(tts_rsp_t r);
        return $sformatf("kind=%0d slot=%0d status=%0d err=%0d last=%0d",
                         r.kind, r.task_slot, r.status, r.error_code, r.last);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // result side: random stall bursts unless calm
    always @(negedge clk)
    begin
        if (calm)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        tts_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_results++;
            if (rsp.kind == KIND_RUN)
                n_runs++;
            if (due_replies.size() == 0)
                flag_error($sformatf("unexpected result %s", fmt_rsp(rsp)));
            else
            begin
                want = due_replies.pop_front();
                if (rsp.kind !== want.kind || rsp.task_slot !== want.task_slot ||
                    rsp.status !== want.status || rsp.error_code !== want.error_code ||
                    rsp.last !== want.last)
                    flag_error($sformatf("result %0d expected %s, got %s",
                                         n_results, fmt_rsp(want), fmt_rsp(rsp)));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] timeout: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic issue_cmd(tts_req_t item);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        cmd_count[item.cmd]++;
        if (item.cmd == CMD_ADD && !(tbl_live.sum() with (int'(!item))))
            n_full++;
        if (item.cmd == CMD_DEL && (int'(item.slot) >= TASK_SLOTS || !tbl_live[item.slot]))
            n_empty_del++;
        apply_to_table(item);
    endtask

    // sender holds off until every reply is back
    task automatic drain_replies();
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));       // nothing due
        issue_cmd(mk_req(CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DEL, 3'd0, 16'd0, 16'd0, 1'b0));        // empty delete
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd0, 1'b0));        // one-shot preemptive
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd1, 16'd2, 1'b0));
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd0, 1'b1));        // one-shot cooperative
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd3, 1'b1));
        issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));       // one-shot coop waits
        issue_cmd(mk_req(CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'hFFFF, 16'hFFFF, 1'b1));
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'hFFFF, 16'd0, 1'b0));
        for (int i = 0; i < 4; i++)
            issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd1, 1'b0));
        issue_cmd(mk_req(CMD_ADD, 3'd7, 16'd5, 16'd5, 1'b1));        // table full
        issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));       // many runs at once
        issue_cmd(mk_req(CMD_DEL, 3'd7, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DEL, 3'd7, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd0, 1'b1));
        issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DEL, 3'd3, 16'd0, 16'd0, 1'b0));
        drain_replies();
    endtask

    // a one-shot cooperative task gains a pending run on every tick; the 256th tick
    // must leave the count pinned at 255, so the dispatch still runs it
    task automatic test_pending_saturation();
        calm = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++)
            issue_cmd(mk_req(CMD_DEL, 3'(i), 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_ADD, 3'd0, 16'd0, 16'd0, 1'b1));
        for (int i = 0; i < 256; i++)
            issue_cmd(mk_req(CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 1'b0));
        issue_cmd(mk_req(CMD_DEL, 3'd0, 16'd0, 16'd0, 1'b0));
        calm = 1'b0;
    endtask

    task automatic test_random_traffic(int count);
        tts_req_t item;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            item = tts_req_t'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                item.cmd = CMD_ADD;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    item.start_delay = $urandom_range(0, 3);
                    item.repeat_period = $urandom_range(0, 4);
                end
                else if (pick < 9)
                begin
                    item.start_delay = $urandom_range(0, 20);
                    item.repeat_period = $urandom_range(0, 20);
                end
            end
            else if (pick < 45)
                item.cmd = CMD_DEL;
            else if (pick < 80)
                item.cmd = CMD_TICK;
            else
                item.cmd = CMD_DISPATCH;
            issue_cmd(item);
        end
    endtask

    initial
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
            drop_slot(i);
        err_latch = ERR_NONE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pending_saturation();
        test_random_traffic(110);
        drain_replies();
        calm = 1'b1;
        test_random_traffic(50);

        drain_replies();
        repeat (TASK_SLOTS * 4 + 20) @(posedge clk);
        if (due_replies.size() != 0)
            flag_error($sformatf("%0d replies never arrived", due_replies.size()));

        $display("covered %0d adds, %0d deletes, %0d ticks, %0d dispatches; %0d results, %0d runs",
                 cmd_count[CMD_ADD], cmd_count[CMD_DEL], cmd_count[CMD_TICK],
                 cmd_count[CMD_DISPATCH], n_results, n_runs);
        $display("%0d adds to a full table, %0d deletes of empty slots, %0d mismatches",
                 n_full, n_empty_del, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
